// ===== hdl/e2q_pkg.sv =====
package e2q_pkg;

  localparam int ANGLE_W = 16;
  localparam int QUAT_W = 16;
  localparam int STEPS = 16;
  localparam int FRAC = 30;
  // q2.30 working values plus headroom for cordic growth and the range fold
  localparam int WW = 35;

  localparam logic signed [WW-1:0] GAIN_INV = 35'sd652032874;
  localparam logic signed [WW-1:0] HALF_PI = 35'sd1686629713;
  localparam logic signed [WW-1:0] PI_Q = 35'sd3373259426;

  typedef logic signed [WW-1:0] word_t;

  function automatic word_t atan_q30(input int i);
    word_t r;
    r = '0;
    case (i)
      0: r = 35'sd843314857;
      1: r = 35'sd497837829;
      2: r = 35'sd263043837;
      3: r = 35'sd133525159;
      4: r = 35'sd67021687;
      5: r = 35'sd33543516;
      6: r = 35'sd16775851;
      7: r = 35'sd8388437;
      8: r = 35'sd4194283;
      9: r = 35'sd2097149;
      default: begin
        if (i < 31) r = word_t'(64'sd1 <<< (30 - i));
        else r = '0;
      end
    endcase
    return r;
  endfunction

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    logic  flip;
  } cstate_t;

  // two-factor q2.30 product rounded back to q2.30
  function automatic word_t mulq(input word_t a, input word_t b);
    logic signed [2*WW-1:0] p;
    p = a * b + (70'sd1 <<< (FRAC - 1));
    return word_t'(p >>> FRAC);
  endfunction

endpackage

// ===== hdl/e2q_cordic.sv =====
module e2q_cordic (
  input  logic                              clk,
  input  logic                              adv,
  input  logic signed [e2q_pkg::ANGLE_W-1:0] angle,
  output e2q_pkg::word_t                    cos_o,
  output e2q_pkg::word_t                    sin_o
);
  import e2q_pkg::*;

  cstate_t st_r [STEPS+1];
  cstate_t st0;
  word_t h;

  always_comb begin
    h = word_t'(angle) <<< (32 - ANGLE_W);
    st0.x = GAIN_INV;
    st0.y = '0;
    st0.flip = 1'b0;
    st0.z = h;
    if (h > HALF_PI) begin
      st0.z = h - PI_Q;
      st0.flip = 1'b1;
    end else if (h < -HALF_PI) begin
      st0.z = h + PI_Q;
      st0.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) st_r[0] <= st0;
  end

  // one micro-rotation per register stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!st_r[i].z[WW-1]) begin
          st_r[i+1].x <= st_r[i].x - (st_r[i].y >>> i);
          st_r[i+1].y <= st_r[i].y + (st_r[i].x >>> i);
          st_r[i+1].z <= st_r[i].z - atan_q30(i);
        end else begin
          st_r[i+1].x <= st_r[i].x + (st_r[i].y >>> i);
          st_r[i+1].y <= st_r[i].y - (st_r[i].x >>> i);
          st_r[i+1].z <= st_r[i].z + atan_q30(i);
        end
        st_r[i+1].flip <= st_r[i].flip;
      end
    end
  end

  assign cos_o = st_r[STEPS].flip ? -st_r[STEPS].x : st_r[STEPS].x;
  assign sin_o = st_r[STEPS].flip ? -st_r[STEPS].y : st_r[STEPS].y;

endmodule

// ===== hdl/e2q_combine.sv =====
module e2q_combine (
  input  logic                               clk,
  input  logic                               adv,
  input  e2q_pkg::word_t                     cr,
  input  e2q_pkg::word_t                     sr,
  input  e2q_pkg::word_t                     cp,
  input  e2q_pkg::word_t                     sp,
  input  e2q_pkg::word_t                     cy,
  input  e2q_pkg::word_t                     sy,
  output logic signed [e2q_pkg::QUAT_W-1:0]  qw,
  output logic signed [e2q_pkg::QUAT_W-1:0]  qx,
  output logic signed [e2q_pkg::QUAT_W-1:0]  qy,
  output logic signed [e2q_pkg::QUAT_W-1:0]  qz
);
  import e2q_pkg::*;

  localparam int SH = 32 - QUAT_W;
  localparam logic signed [WW:0] LIM = (WW+1)'(1) <<< (QUAT_W - 2);

  word_t cy_r, sy_r, crcp_r, srsp_r, srcp_r, crsp_r;
  word_t t_r [8];
  logic signed [WW:0] s_r [4];

  function automatic logic signed [QUAT_W-1:0] to_out(input logic signed [WW:0] v);
    logic signed [WW:0] r;
    r = v;
    if (SH > 0) r = (v + ((WW+1)'(1) <<< (SH - 1))) >>> SH;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return r[QUAT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      crcp_r <= mulq(cr, cp);
      srsp_r <= mulq(sr, sp);
      srcp_r <= mulq(sr, cp);
      crsp_r <= mulq(cr, sp);
      cy_r <= cy;
      sy_r <= sy;
      t_r[0] <= mulq(crcp_r, cy_r);
      t_r[1] <= mulq(srsp_r, sy_r);
      t_r[2] <= mulq(srcp_r, cy_r);
      t_r[3] <= mulq(crsp_r, sy_r);
      t_r[4] <= mulq(crsp_r, cy_r);
      t_r[5] <= mulq(srcp_r, sy_r);
      t_r[6] <= mulq(crcp_r, sy_r);
      t_r[7] <= mulq(srsp_r, cy_r);
      s_r[0] <= (WW+1)'(t_r[0]) + (WW+1)'(t_r[1]);
      s_r[1] <= (WW+1)'(t_r[2]) - (WW+1)'(t_r[3]);
      s_r[2] <= (WW+1)'(t_r[4]) + (WW+1)'(t_r[5]);
      s_r[3] <= (WW+1)'(t_r[6]) - (WW+1)'(t_r[7]);
    end
  end

  assign qw = to_out(s_r[0]);
  assign qx = to_out(s_r[1]);
  assign qy = to_out(s_r[2]);
  assign qz = to_out(s_r[3]);

endmodule

// ===== hdl/euler_to_quaternion_unit.sv =====
// channel | ports                                         | direction
// in      | in_valid in_stall in_roll/pitch/yaw_angle     | item in
//         | in_coord_system                               |
// out     | out_valid out_stall out_quat_w/x/y/z          | result out
//         | out_coord_tag                                 |
// one item per cycle unless stalled; stages: the range-fold register, one register
// per cordic step and three product/sum stages, outputs decoded from the last one.
// reset clears the valid bits only; the datapath registers are not reset.
// a stall at the output freezes the whole pipe when the last stage holds a result;
// in_stall follows the freeze, so bubbles drain while stalled.
module euler_to_quaternion_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [e2q_pkg::ANGLE_W-1:0] in_roll_angle,
  input  logic signed [e2q_pkg::ANGLE_W-1:0] in_pitch_angle,
  input  logic signed [e2q_pkg::ANGLE_W-1:0] in_yaw_angle,
  input  logic [1:0]                         in_coord_system,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [e2q_pkg::QUAT_W-1:0]  out_quat_w,
  output logic signed [e2q_pkg::QUAT_W-1:0]  out_quat_x,
  output logic signed [e2q_pkg::QUAT_W-1:0]  out_quat_y,
  output logic signed [e2q_pkg::QUAT_W-1:0]  out_quat_z,
  output logic [1:0]                         out_coord_tag
);
  import e2q_pkg::*;

  localparam int LAT = STEPS + 4;

  logic [LAT-1:0] vld_r;
  logic [1:0] tag_r [LAT];
  logic adv;
  word_t cr, sr, cp, sp, cy, sy;

  // pipe advances unless a finished result is held back
  assign adv = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r[0] <= in_coord_system;
      for (int i = 1; i < LAT; i++) tag_r[i] <= tag_r[i-1];
    end
  end

  e2q_cordic u_roll (.clk, .adv, .angle(in_roll_angle), .cos_o(cr), .sin_o(sr));
  e2q_cordic u_pitch (.clk, .adv, .angle(in_pitch_angle), .cos_o(cp), .sin_o(sp));
  e2q_cordic u_yaw (.clk, .adv, .angle(in_yaw_angle), .cos_o(cy), .sin_o(sy));

  e2q_combine u_comb (
    .clk, .adv, .cr, .sr, .cp, .sp, .cy, .sy,
    .qw(out_quat_w), .qx(out_quat_x), .qy(out_quat_y), .qz(out_quat_z)
  );

  assign out_valid = vld_r[LAT-1];
  assign out_coord_tag = tag_r[LAT-1];

endmodule
